FILE: hw/rtl/pdvm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdvm_pkg
// Shared types, register indexes and helpers for the perspective divide and
// viewport map block.
// ----------------------------------------------------------------------------
package pdvm_pkg;

  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned DepthFrac   = 16;

  typedef struct packed {
    logic signed [31:0] clip_x;
    logic signed [31:0] clip_y;
    logic signed [31:0] clip_z;
    logic signed [31:0] clip_w;
  } vertex_t;

  typedef struct packed {
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic signed [31:0] depth_out;
    logic signed [31:0] recip_w;
  } result_t;

  typedef enum logic [2:0] {
    RegViewLeft   = 3'd0,
    RegViewTop    = 3'd1,
    RegViewWidth  = 3'd2,
    RegViewHeight = 3'd3,
    RegDepthNear  = 3'd4,
    RegDepthFar   = 3'd5
  } cfg_idx_e;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] res;
    if (v > 64'sd2147483647) begin
      res = 32'h7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      res = 32'h8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/pdvm_recip.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdvm_recip
// Pipelined restoring divider for 2^(2F) / d, one quotient bit per stage,
// with a side bus carried along.
// ----------------------------------------------------------------------------
module pdvm_recip
  import pdvm_pkg::*;
#(
  parameter int unsigned FracBits = FracBitsDef,
  parameter int unsigned SideW    = 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  input  wire logic [31:0]           divisor_i,
  input  wire logic [SideW-1:0]      side_i,
  output logic                       valid_o,
  output logic [2*FracBits:0]        quot_o,
  output logic [SideW-1:0]           side_o
);

  localparam int unsigned Steps = 2 * FracBits + 1;
  localparam int unsigned RemW  = 33;

  logic [Steps-1:0] vld_q;
  logic [RemW-1:0]  rem_q  [Steps];
  logic [Steps-1:0] quo_q  [Steps];
  logic [31:0]      div_q  [Steps];
  logic [SideW-1:0] side_q [Steps];

  for (genvar s = 0; s < Steps; s++) begin : g_step
    logic             v_in;
    logic [RemW-1:0]  trial;
    logic [Steps-1:0] q_in;
    logic [31:0]      d_in;
    logic [SideW-1:0] x_in;
    logic             ge;

    if (s == 0) begin : g_first
      assign v_in  = valid_i;
      assign trial = RemW'(1);
      assign q_in  = '0;
      assign d_in  = divisor_i;
      assign x_in  = side_i;
    end else begin : g_next
      assign v_in  = vld_q[s-1];
      assign trial = {rem_q[s-1][RemW-2:0], 1'b0};
      assign q_in  = quo_q[s-1];
      assign d_in  = div_q[s-1];
      assign x_in  = side_q[s-1];
    end

    assign ge = trial >= {1'b0, d_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= ge ? (trial - {1'b0, d_in}) : trial;
      quo_q[s]  <= {q_in[Steps-2:0], ge};
      div_q[s]  <= d_in;
      side_q[s] <= x_in;
    end
  end

  assign valid_o = vld_q[Steps-1];
  assign quot_o  = quo_q[Steps-1];
  assign side_o  = side_q[Steps-1];

endmodule
`default_nettype wire

FILE: hw/rtl/perspective_divide_viewport_map.sv
`default_nettype none
// ----------------------------------------------------------------------------
// perspective_divide_viewport_map
// Clip-space vertex to screen x/y, depth and 1/w, signed fixed point,
// saturated results.
//
// channel   | signals                                  | transfer when
// vertex in | start, busy, vertex_i                    | start & !busy
// result    | result_valid_o, result_o                 | result_valid_o
// config    | psel penable pwrite paddr pwdata prdata  | psel & penable & pwrite
//
// one vertex per cycle; the reciprocal divider resolves one quotient bit per stage
// reset clears all valid bits and loads register defaults
// busy stays low: the result side cannot stall, so nothing holds the pipe
// ----------------------------------------------------------------------------
module perspective_divide_viewport_map
  import pdvm_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire vertex_t     vertex_i,
  output logic             result_valid_o,
  output result_t          result_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned QuotW = 2 * FRAC_BITS + 1;
  localparam int unsigned SideW = 3 * 32 + 1;
  localparam int unsigned Lat   = QuotW + 6;

  // config registers
  logic [13:0] left_q, top_q;
  logic [14:0] width_q, height_q;
  logic [16:0] near_q, far_q;
  cfg_idx_e    cfg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign cfg_idx = cfg_idx_e'(paddr[4:2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      top_q    <= '0;
      width_q  <= 15'd640;
      height_q <= 15'd480;
      near_q   <= '0;
      far_q    <= 17'd65536;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegViewLeft:   left_q   <= pwdata[13:0];
        RegViewTop:    top_q    <= pwdata[13:0];
        RegViewWidth:  width_q  <= pwdata[14:0];
        RegViewHeight: height_q <= pwdata[14:0];
        RegDepthNear:  near_q   <= pwdata[16:0];
        RegDepthFar:   far_q    <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegViewLeft:   prdata = 32'(left_q);
      RegViewTop:    prdata = 32'(top_q);
      RegViewWidth:  prdata = 32'(width_q);
      RegViewHeight: prdata = 32'(height_q);
      RegDepthNear:  prdata = 32'(near_q);
      RegDepthFar:   prdata = 32'(far_q);
      default:       prdata = '0;
    endcase
  end

  // stage: input capture
  logic    in_vld_q;
  vertex_t in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q <= vertex_i;
  end

  // stage: reciprocal divider
  logic              w_neg, w_zero;
  logic [31:0]       w_mag;
  logic              dv_vld;
  logic [QuotW-1:0]  dv_quot;
  logic [SideW-1:0]  dv_side;
  logic              dv_neg, dv_zero;

  assign w_neg  = in_q.clip_w[31];
  assign w_zero = (in_q.clip_w == '0);
  assign w_mag  = w_neg ? (32'd0 - in_q.clip_w) : in_q.clip_w;

  pdvm_recip #(
    .FracBits (FRAC_BITS),
    .SideW    (SideW + 1)
  ) u_recip (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_vld_q),
    .divisor_i (w_zero ? 32'd1 : w_mag),
    .side_i    ({in_q.clip_x, in_q.clip_y, in_q.clip_z, w_zero, w_neg}),
    .valid_o   (dv_vld),
    .quot_o    (dv_quot),
    .side_o    ({dv_side, dv_neg})
  );

  assign dv_zero = dv_side[0];

  // stage: sign and saturate reciprocal
  logic               r_vld_q;
  logic signed [31:0] r_d, r_q;
  logic signed [31:0] rx_q, ry_q, rz_q;
  logic [63:0]        q_ext;

  assign q_ext = 64'(dv_quot);

  always_comb begin
    if (dv_zero) begin
      r_d = 32'(64'd1 << FRAC_BITS);
    end else if (!dv_neg) begin
      r_d = (q_ext > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q_ext[31:0];
    end else begin
      r_d = (q_ext > 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - q_ext);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_vld_q <= 1'b0;
    end else begin
      r_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q  <= r_d;
    rx_q <= dv_side[SideW-1 -: 32];
    ry_q <= dv_side[SideW-33 -: 32];
    rz_q <= dv_side[SideW-65 -: 32];
  end

  // stage: scale by reciprocal
  logic               p_vld_q;
  logic signed [63:0] px_q, py_q, pz_q;
  logic signed [31:0] pr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else begin
      p_vld_q <= r_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q <= rx_q * r_q;
    py_q <= ry_q * r_q;
    pz_q <= rz_q * r_q;
    pr_q <= r_q;
  end

  // stage: normalize
  logic               n_vld_q;
  logic signed [31:0] nx_q, ny_q, nz_q, nr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_vld_q <= 1'b0;
    end else begin
      n_vld_q <= p_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    nx_q <= sat32(px_q >>> FRAC_BITS);
    ny_q <= sat32(py_q >>> FRAC_BITS);
    nz_q <= sat32(pz_q >>> FRAC_BITS);
    nr_q <= pr_q;
  end

  // stage: viewport and depth products
  logic               m_vld_q;
  logic signed [32:0] ny_neg;
  logic signed [17:0] dz;
  logic signed [47:0] mx_q;
  logic signed [48:0] my_q;
  logic signed [49:0] mz_q;
  logic signed [31:0] mr_q;

  assign ny_neg = 33'sd0 - 33'(ny_q);
  assign dz     = $signed({1'b0, far_q}) - $signed({1'b0, near_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else begin
      m_vld_q <= n_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q <= nx_q * $signed({1'b0, width_q});
    my_q <= ny_neg * $signed({1'b0, height_q});
    mz_q <= nz_q * dz;
    mr_q <= nr_q;
  end

  // stage: offsets and output register
  logic signed [63:0] base_x, base_y, half_x, half_y, near_f;
  logic signed [63:0] sx, sy, sz;
  logic               out_vld_q;
  result_t            out_q;

  assign base_x = 64'(left_q) << FRAC_BITS;
  assign base_y = 64'(top_q) << FRAC_BITS;
  assign half_x = (64'(width_q) << FRAC_BITS) >> 1;
  assign half_y = (64'(height_q) << FRAC_BITS) >> 1;
  assign near_f = (64'(near_q) << FRAC_BITS) >> DepthFrac;

  assign sx = 64'(mx_q >>> 1) + base_x + half_x;
  assign sy = 64'(my_q >>> 1) + base_y + half_y;
  assign sz = 64'(mz_q >>> DepthFrac) + near_f;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q.screen_x  <= sat32(sx);
    out_q.screen_y  <= sat32(sy);
    out_q.depth_out <= sat32(sz);
    out_q.recip_w   <= mr_q;
  end

  assign result_valid_o = out_vld_q;
  assign result_o       = out_q;

  // checks
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Lat result_valid_o)
    else $error("accepted vertex did not come out after the pipe latency");

  a_no_phantom : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |-> ##Lat !result_valid_o)
    else $error("result strobe without an accepted vertex");

  a_recip_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.recip_w != '0))
    else $error("reciprocal of w came out as zero");

endmodule
`default_nettype wire
